[sv/resource_claim_table_unit_assert.svh]
// Assertion macros used by the resource claim table top level.
`ifndef RESOURCE_CLAIM_TABLE_UNIT_ASSERT_SVH
`define RESOURCE_CLAIM_TABLE_UNIT_ASSERT_SVH

// Clocked check that is switched off while reset is held.
`define RCT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rct_pkg.sv]
// Types, sizes and codes of the resource claim table.
package rct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int RESOURCE_BITS = 16;
    localparam int OWNER_BITS    = 8;
    localparam int KIND_BITS     = 3;
    localparam int OP_BITS       = 2;
    localparam int STATUS_BITS   = 2;
    localparam int COUNT_BITS    = 5;

    localparam logic [OP_BITS-1:0] OP_CLAIM   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_RELEASE = 2'd1;

    localparam logic [STATUS_BITS-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_OTHER    = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_FULL     = 2'd2;
    localparam logic [STATUS_BITS-1:0] STAT_NOT_HELD = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_RESOLVE,
        ST_COMMIT
    } state_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic                     match_en;
        logic                     resolve_en;
        logic                     write_en;
        logic                     clear_en;
        logic [KIND_BITS-1:0]     kind;
        logic [RESOURCE_BITS-1:0] resource;
        logic [OWNER_BITS-1:0]    owner;
    } cell_cmd_t;

    // Link handed from one cell to the next higher cell.
    typedef struct packed {
        logic                  hit_seen;
        logic                  free_seen;
        logic [OWNER_BITS-1:0] holder;
    } cell_link_t;

    // Per-cell status seen by the top level.
    typedef struct packed {
        logic valid;
        logic first_hit;
        logic first_free;
    } cell_stat_t;

endpackage

[sv/rct_cell.sv]
// One entry of the claim table with its match and priority link logic.
module rct_cell
    import rct_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_cmd_t  cmd,
    input  cell_link_t link_in,
    output cell_link_t link_out,
    output cell_stat_t stat
);

    logic                     valid_reg, valid_next;
    logic                     hit_reg, hit_next;
    logic                     first_hit_reg, first_hit_next;
    logic                     first_free_reg, first_free_next;
    logic [KIND_BITS-1:0]     kind_reg;
    logic [RESOURCE_BITS-1:0] resource_reg;
    logic [OWNER_BITS-1:0]    owner_reg;
    logic                     load;

    // Link to the next cell: a lower hit or free entry masks this one.
    always_comb begin
        link_out.hit_seen  = link_in.hit_seen | hit_reg;
        link_out.free_seen = link_in.free_seen | ~valid_reg;
        link_out.holder    = (hit_reg && !link_in.hit_seen) ? owner_reg : link_in.holder;
    end

    // Next values of the control bits.
    always_comb begin
        load            = cmd.write_en && first_free_reg;
        hit_next        = hit_reg;
        first_hit_next  = first_hit_reg;
        first_free_next = first_free_reg;
        valid_next      = valid_reg;
        if (cmd.match_en) begin
            hit_next = valid_reg && (kind_reg == cmd.kind) && (resource_reg == cmd.resource);
        end
        if (cmd.resolve_en) begin
            first_hit_next  = hit_reg && !link_in.hit_seen;
            first_free_next = !valid_reg && !link_in.free_seen;
        end
        if (load) begin
            valid_next = 1'b1;
        end else if (cmd.clear_en && first_hit_reg) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            first_hit_reg  <= 1'b0;
            first_free_reg <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            hit_reg        <= hit_next;
            first_hit_reg  <= first_hit_next;
            first_free_reg <= first_free_next;
        end
    end

    // Entry contents are written only when this cell takes a claim.
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg     <= cmd.kind;
            resource_reg <= cmd.resource;
            owner_reg    <= cmd.owner;
        end
    end

    assign stat.valid      = valid_reg;
    assign stat.first_hit  = first_hit_reg;
    assign stat.first_free = first_free_reg;

endmodule

[sv/resource_claim_table_unit.sv]
// Top level of the resource claim table: controller, result register and cell row.
//
// The input stream carries one request per beat: claim, release or query of one
// resource, identified by kind and number, on behalf of one owner. The output
// stream returns exactly one result per request, in order: success, status,
// whether the resource is held afterwards, the holder and the held entry count.
// There is no configuration port.
//
// A request passes through the accept state, a match state in which every
// cell compares its entry, a resolve state in which the row of cells passes the
// lowest hit, lowest free entry and holder from cell to cell, and a commit state
// in which the table and the result register are updated. The result is valid
// in the cycle after commit, so the next request is taken only once commit is
// done; the block takes no new request while one is still in progress.
//
// A finished result waits in the output register while the next request is
// taken. If the receiver stalls with a result still waiting, the next request
// stays in its commit cycle until the register frees up. Reset frees every
// entry and clears the count at once; no clearing pass is needed.
`include "resource_claim_table_unit_assert.svh"

module resource_claim_table_unit
    import rct_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] operation, [4:2] resource_kind, [20:5] resource_number,
    // [28:21] owner_number, [31:29] zero
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] success, [2:1] status_code, [3] is_held, [11:4] holder_number,
    // [16:12] held_count, [23:17] zero
    output logic [23:0] m_tdata
);

    state_t state_reg, state_next;

    logic [OP_BITS-1:0]       op_reg;
    logic [KIND_BITS-1:0]     kind_reg;
    logic [RESOURCE_BITS-1:0] resource_reg;
    logic [OWNER_BITS-1:0]    owner_reg;

    logic                     any_hit_reg;
    logic                     any_free_reg;
    logic [OWNER_BITS-1:0]    holder_reg;
    logic [COUNT_BITS-1:0]    count_reg, count_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     out_success_reg;
    logic [STATUS_BITS-1:0]   out_status_reg;
    logic                     out_held_reg;
    logic [OWNER_BITS-1:0]    out_holder_reg;
    logic [COUNT_BITS-1:0]    out_count_reg;

    logic                     in_fire;
    logic                     slot_open;
    logic                     commit;
    logic                     match_en;
    logic                     resolve_en;
    logic                     own_match;
    logic                     do_write;
    logic                     do_clear;
    logic                     res_success;
    logic [STATUS_BITS-1:0]   res_status;
    logic                     res_held;
    logic [OWNER_BITS-1:0]    res_holder;

    cell_cmd_t                cmd;
    cell_link_t               link [TABLE_ENTRIES+1];
    cell_stat_t               stat [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_vec;
    logic [TABLE_ENTRIES-1:0] first_hit_vec;
    logic [TABLE_ENTRIES-1:0] first_free_vec;

    assign in_fire   = s_tvalid && s_tready;
    assign slot_open = !out_valid_reg || m_tready;

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_MATCH;
            ST_MATCH:   state_next = ST_RESOLVE;
            ST_RESOLVE: state_next = ST_COMMIT;
            ST_COMMIT:  if (slot_open) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready   = 1'b0;
        match_en   = 1'b0;
        resolve_en = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_tready   = 1'b1;
            ST_MATCH:   match_en   = 1'b1;
            ST_RESOLVE: resolve_en = 1'b1;
            ST_COMMIT:  commit     = slot_open;
            default:    s_tready   = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Request capture.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg       <= s_tdata[1:0];
            kind_reg     <= s_tdata[4:2];
            resource_reg <= s_tdata[20:5];
            owner_reg    <= s_tdata[28:21];
        end
    end

    assign cmd = '{match_en: match_en, resolve_en: resolve_en, write_en: do_write,
                   clear_en: do_clear, kind: kind_reg, resource: resource_reg,
                   owner: owner_reg};

    // Row of cells; the link runs from entry zero upward.
    assign link[0] = '{hit_seen: 1'b0, free_seen: 1'b0, holder: '0};

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        rct_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .link_in  (link[g]),
            .link_out (link[g+1]),
            .stat     (stat[g])
        );
        assign valid_vec[g]      = stat[g].valid;
        assign first_hit_vec[g]  = stat[g].first_hit;
        assign first_free_vec[g] = stat[g].first_free;
    end

    // Summary of the row, taken at the end of the resolve cycle.
    always_ff @(posedge aclk) begin
        if (cmd.resolve_en) begin
            any_hit_reg  <= link[TABLE_ENTRIES].hit_seen;
            any_free_reg <= link[TABLE_ENTRIES].free_seen;
            holder_reg   <= link[TABLE_ENTRIES].holder;
        end
    end

    // Decision for the request in its commit cycle.
    always_comb begin
        own_match   = (holder_reg == owner_reg);
        do_write    = 1'b0;
        do_clear    = 1'b0;
        res_success = 1'b0;
        res_status  = STAT_NOT_HELD;
        res_held    = 1'b0;
        res_holder  = '0;
        count_next  = count_reg;
        priority if (op_reg == OP_CLAIM) begin
            if (any_hit_reg) begin
                res_held    = 1'b1;
                res_holder  = holder_reg;
                res_success = own_match;
                res_status  = own_match ? STAT_OK : STAT_OTHER;
            end else if (any_free_reg) begin
                do_write    = commit;
                res_success = 1'b1;
                res_status  = STAT_OK;
                res_held    = 1'b1;
                res_holder  = owner_reg;
                count_next  = count_reg + COUNT_BITS'(1);
            end else begin
                res_status  = STAT_FULL;
            end
        end else if (op_reg == OP_RELEASE) begin
            if (any_hit_reg && own_match) begin
                do_clear    = commit;
                res_success = 1'b1;
                res_status  = STAT_OK;
                count_next  = count_reg - COUNT_BITS'(1);
            end else if (any_hit_reg) begin
                res_status  = STAT_OTHER;
                res_held    = 1'b1;
                res_holder  = holder_reg;
            end
        end else begin
            if (any_hit_reg) begin
                res_success = 1'b1;
                res_status  = STAT_OK;
                res_held    = 1'b1;
                res_holder  = holder_reg;
            end
        end
    end

    // Held entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (commit) begin
            count_reg <= count_next;
        end
    end

    // Result register.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_success_reg <= res_success;
            out_status_reg  <= res_status;
            out_held_reg    <= res_held;
            out_holder_reg  <= res_holder;
            out_count_reg   <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_count_reg, out_holder_reg, out_held_reg,
                       out_status_reg, out_success_reg};

    // The count always equals the number of valid entries.
    `RCT_ASSERT(a_count_matches, aclk, aresetn, (count_reg == COUNT_BITS'($countones(valid_vec))), "held count differs from valid entries")
    // At most one cell is chosen as lowest hit and as lowest free entry.
    `RCT_ASSERT(a_one_hit, aclk, aresetn, ($onehot0(first_hit_vec) && $onehot0(first_free_vec)), "more than one cell selected")
    // A claim into the table only happens where a free entry was found.
    `RCT_ASSERT(a_write_free, aclk, aresetn, (do_write |-> (any_free_reg && !any_hit_reg)), "claim written without a free entry")
    // A new result appears only after a commit cycle.
    `RCT_ASSERT(a_result_after_commit, aclk, aresetn, ($rose(m_tvalid) |-> $past(state_reg) == ST_COMMIT), "result without commit")
    // No request is accepted while the sequencer is busy.
    `RCT_ASSERT(a_accept_idle, aclk, aresetn, (in_fire |=> state_reg == ST_MATCH), "request taken while busy")

endmodule

[tb/resource_claim_table_checker.sv]
// Checker for the resource claim table: mirrors the table, predicts each result and compares.
module resource_claim_table_checker
    import rct_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          failure_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;
    localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;

    typedef struct packed {
        logic                    success;
        logic [STATUS_BITS-1:0]  status;
        logic                    is_held;
        logic [OWNER_BITS-1:0]   holder;
        logic [COUNT_BITS-1:0]   held_count;
    } claim_outcome_t;

    // Shadow copy of the ownership table.
    logic                     entry_used     [TABLE_ENTRIES];
    logic [KIND_BITS-1:0]     entry_kind     [TABLE_ENTRIES];
    logic [RESOURCE_BITS-1:0] entry_resource [TABLE_ENTRIES];
    logic [OWNER_BITS-1:0]    entry_owner    [TABLE_ENTRIES];
    int                       held_total;

    claim_outcome_t expected_outcomes[$];
    int             mismatches;

    assign failure_count = mismatches;
    assign pending_count = expected_outcomes.size();

    // Applies one request to the shadow table and returns the result it must produce.
    function automatic claim_outcome_t resolve_request(input logic [31:0] word);
        logic [OP_BITS-1:0]       op;
        logic [KIND_BITS-1:0]     kind;
        logic [RESOURCE_BITS-1:0] res;
        logic [OWNER_BITS-1:0]    own;
        int                       hit;
        int                       slot;
        claim_outcome_t           o;
        op   = word[1:0];
        kind = word[4:2];
        res  = word[20:5];
        own  = word[28:21];
        o    = '{success: 1'b0, status: STAT_NOT_HELD, is_held: 1'b0, holder: '0,
                 held_count: '0};

        // Lowest valid entry holding this resource, and lowest free entry.
        hit  = -1;
        slot = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit < 0 && entry_used[i] && entry_kind[i] == kind && entry_resource[i] == res)
                hit = i;
            if (slot < 0 && !entry_used[i])
                slot = i;
        end

        case (op)
            OP_CLAIM: begin
                if (hit >= 0) begin
                    o.is_held = 1'b1;
                    o.holder  = entry_owner[hit];
                    if (entry_owner[hit] == own) begin
                        o.success = 1'b1;
                        o.status  = STAT_OK;
                    end else begin
                        o.status = STAT_OTHER;
                    end
                end else if (slot >= 0) begin
                    entry_used[slot]     = 1'b1;
                    entry_kind[slot]     = kind;
                    entry_resource[slot] = res;
                    entry_owner[slot]    = own;
                    held_total++;
                    o.success = 1'b1;
                    o.status  = STAT_OK;
                    o.is_held = 1'b1;
                    o.holder  = own;
                end else begin
                    o.status = STAT_FULL;
                end
            end
            OP_RELEASE: begin
                if (hit >= 0) begin
                    if (entry_owner[hit] == own) begin
                        entry_used[hit]  = 1'b0;
                        entry_owner[hit] = '0;
                        if (held_total > 0)
                            held_total--;
                        o.success = 1'b1;
                        o.status  = STAT_OK;
                    end else begin
                        o.status  = STAT_OTHER;
                        o.is_held = 1'b1;
                        o.holder  = entry_owner[hit];
                    end
                end
            end
            default: begin
                // Query, and the unused operation code, never change the table.
                if (hit >= 0) begin
                    o.success = 1'b1;
                    o.status  = STAT_OK;
                    o.is_held = 1'b1;
                    o.holder  = entry_owner[hit];
                end
            end
        endcase

        o.held_count = (held_total > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                                : held_total[COUNT_BITS-1:0];
        return o;
    endfunction

    initial mismatches = 0;

    // Results are checked before the request of the same edge is added to the queue.
    always @(posedge aclk) begin
        claim_outcome_t seen;
        claim_outcome_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                entry_used[i]     = 1'b0;
                entry_kind[i]     = '0;
                entry_resource[i] = '0;
                entry_owner[i]    = '0;
            end
            held_total = 0;
            expected_outcomes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen = '{success: m_tdata[0], status: m_tdata[2:1], is_held: m_tdata[3],
                         holder: m_tdata[11:4], held_count: m_tdata[16:12]};
                if (expected_outcomes.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: result with no request outstanding: m_tdata=%h",
                                 $realtime, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (seen.success !== want.success || seen.status !== want.status ||
                        seen.is_held !== want.is_held || seen.holder !== want.holder ||
                        seen.held_count !== want.held_count) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $write("%0t: result mismatch: expected success=%0b status=%0d ",
                                   $realtime, want.success, want.status);
                            $display("held=%0b holder=%0d count=%0d, got success=%0b %s",
                                     want.is_held, want.holder, want.held_count,
                                     seen.success, "");
                            $display("    got status=%0d held=%0b holder=%0d count=%0d",
                                     seen.status, seen.is_held, seen.holder,
                                     seen.held_count);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_outcomes.push_back(resolve_request(s_tdata));
        end
    end

endmodule

[tb/tb.sv]
// Top of the resource claim table testbench: clock, reset, request stimulus and verdict.
module tb
    import rct_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int PHASE_REQUESTS   = 400;
    localparam int POOL_KEYS        = 24;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int DRAIN_CYCLES     = 12;

    localparam logic [OP_BITS-1:0] OP_QUERY       = 2'd2;
    localparam logic [OP_BITS-1:0] OP_QUERY_SPARE = 2'd3;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int failure_count;
    int pending_count;
    int sender_idle_pct   = 13;
    int receiver_idle_pct = 87;
    int quiet_cycles      = 0;
    logic hold_off        = 1'b0;
    logic pressure_go     = 1'b0;

    // Resources that the random requests mostly work on, each with a usual owner.
    logic [KIND_BITS-1:0]     key_kind  [POOL_KEYS];
    logic [RESOURCE_BITS-1:0] key_res   [POOL_KEYS];
    logic [OWNER_BITS-1:0]    key_owner [POOL_KEYS];

    resource_claim_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    resource_claim_table_checker checker_inst (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .failure_count (failure_count),
        .pending_count (pending_count)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] pack_request(input logic [OP_BITS-1:0] op,
                                                 input logic [KIND_BITS-1:0] kind,
                                                 input logic [RESOURCE_BITS-1:0] res,
                                                 input logic [OWNER_BITS-1:0] own);
        return {3'b000, own, res, kind, op};
    endfunction

    // Offers one request after a random gap and returns once it is accepted.
    task automatic send_request(input logic [31:0] word);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Random request on a pooled resource; the mix swings between filling and draining.
    task automatic send_random_request(input int n);
        int                       k;
        int                       roll;
        logic [OP_BITS-1:0]       op;
        logic [KIND_BITS-1:0]     kind;
        logic [RESOURCE_BITS-1:0] res;
        logic [OWNER_BITS-1:0]    own;
        roll = $urandom_range(99);
        if ((n / 60) % 2 == 0)
            op = (roll < 60) ? OP_CLAIM : (roll < 85) ? OP_RELEASE :
                 (roll < 97) ? OP_QUERY : OP_QUERY_SPARE;
        else
            op = (roll < 20) ? OP_CLAIM : (roll < 75) ? OP_RELEASE :
                 (roll < 95) ? OP_QUERY : OP_QUERY_SPARE;
        k    = $urandom_range(POOL_KEYS - 1);
        kind = key_kind[k];
        res  = key_res[k];
        roll = $urandom_range(99);
        own  = (roll < 70) ? key_owner[k] : (roll < 80) ? '0 : (roll < 90) ? '1 :
               OWNER_BITS'($urandom);
        // Stray resources only for requests that cannot leave an entry behind.
        if (op != OP_CLAIM && $urandom_range(99) < 8) begin
            kind = KIND_BITS'($urandom);
            res  = RESOURCE_BITS'($urandom);
        end
        send_request(pack_request(op, kind, res, own));
    endtask

    // Receiver: random stalls, or a long hold-off when the pressure process asks for it.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // One long receiver hold-off while the sender keeps offering requests.
    initial begin
        wait (pressure_go);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Watchdog on cycles in which neither channel moves anything.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus and verdict.
    initial begin
        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        key_kind[0] = '0;
        key_res[0]  = '0;
        key_owner[0] = '0;
        key_kind[1] = '1;
        key_res[1]  = '1;
        key_owner[1] = '1;
        for (int i = 2; i < POOL_KEYS; i++) begin
            key_kind[i]  = KIND_BITS'($urandom);
            key_res[i]   = RESOURCE_BITS'($urandom);
            key_owner[i] = OWNER_BITS'($urandom);
        end

        // Directed: empty lookups, holder and foreign claims, foreign release, queries.
        send_request(pack_request(OP_QUERY, key_kind[0], key_res[0], '0));
        send_request(pack_request(OP_RELEASE, key_kind[0], key_res[0], '0));
        send_request(pack_request(OP_CLAIM, key_kind[0], key_res[0], '0));
        send_request(pack_request(OP_CLAIM, key_kind[0], key_res[0], '0));
        send_request(pack_request(OP_CLAIM, key_kind[0], key_res[0], '1));
        send_request(pack_request(OP_RELEASE, key_kind[0], key_res[0], '1));
        send_request(pack_request(OP_QUERY, key_kind[0], key_res[0], '1));
        send_request(pack_request(OP_QUERY_SPARE, key_kind[0], key_res[0], '1));
        send_request(pack_request(OP_CLAIM, key_kind[1], key_res[1], key_owner[1]));
        // Fill the table, then a claim that finds no free entry, then a good release.
        for (int i = 2; i < TABLE_ENTRIES; i++)
            send_request(pack_request(OP_CLAIM, key_kind[i], key_res[i], key_owner[i]));
        send_request(pack_request(OP_CLAIM, key_kind[TABLE_ENTRIES], key_res[TABLE_ENTRIES],
                                  key_owner[TABLE_ENTRIES]));
        send_request(pack_request(OP_RELEASE, key_kind[0], key_res[0], '0));

        // Random part in three idling phases; the last one also carries the hold-off.
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct   = (phase == 0) ? 13 : (phase == 1) ? 87 : 0;
            receiver_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 13 : 0;
            if (phase == 2)
                pressure_go = 1'b1;
            for (int n = 0; n < PHASE_REQUESTS; n++)
                send_random_request(n);
        end
        s_tvalid <= 1'b0;

        // Let the checker queue the last request before waiting for the queue to drain.
        @(posedge aclk);
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failure_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/rct_pkg.sv
sv/rct_cell.sv
sv/resource_claim_table_unit.sv
tb/resource_claim_table_checker.sv
tb/tb.sv
